/* rtl/midi_note_duration_tracker_assert.svh */
// ----------------------------------------------------------------------------
// MIDI note duration tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_DURATION_TRACKER_ASSERT_SVH
`define MIDI_NOTE_DURATION_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define MNDT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mndt: same-cycle check failed");

// Next-cycle implication.
`define MNDT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mndt: next-cycle check failed");

`endif

/* rtl/mndt_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI note duration tracker package
// Beat types, message codes and slot table geometry.
// ----------------------------------------------------------------------------
package mndt_pkg;

  localparam int CHAN_BITS  = 4;
  localparam int PITCH_BITS = 7;
  localparam int ADDR_BITS  = CHAN_BITS + PITCH_BITS;

  localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
  localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

  localparam logic KIND_COMPLETE  = 1'b0;
  localparam logic KIND_UNMATCHED = 1'b1;

  typedef enum logic [1:0] {
    MSG_OTHER,
    MSG_ON,
    MSG_OFF
  } msg_kind_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [31:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic        event_kind;
    logic [3:0]  note_channel;
    logic [6:0]  note_pitch;
    logic [31:0] start_time;
    logic [31:0] note_length;
  } out_item_t;

endpackage

/* rtl/midi_note_duration_tracker.sv */
// ----------------------------------------------------------------------------
// MIDI note duration tracker
// Pairs note-on and note-off messages per channel and pitch and reports each
// completed note with its start time and length, or an unmatched note-off.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Beat
//   in_       input      one MIDI channel message with its tick time
//   out_      output     one completed note or unmatched note-off
//
// A message is taken every cycle while in_stall is low; its result is
// registered in the second stage and then in the output register. The rate is
// set by the single slot table read-modify-write: the read is issued on accept,
// the update is written from the second stage, and a back-to-back message to
// the same slot takes the update by forwarding. After reset a clearing pass
// writes all 2048 slots, during which in_stall is high. A stalled result holds
// the second stage and then in_stall.
//
module midi_note_duration_tracker #(
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mndt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mndt_pkg::out_item_t out_data
);

  localparam int ABITS = mndt_pkg::ADDR_BITS;
  localparam int WBITS = TIME_BITS + 1;
  localparam logic [ABITS-1:0] LAST_ADDR = {ABITS{1'b1}};

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [WBITS-1:0]     word_t;

  // Clearing pass.
  logic             clearing_r, clearing_nxt;
  logic [ABITS-1:0] clr_cnt_r, clr_cnt_nxt;

  // Decode of the incoming beat.
  logic                in_accept;
  logic [3:0]          in_type;
  mndt_pkg::msg_kind_t in_kind;
  logic [ABITS-1:0]    in_key;
  tick_t               in_now;

  // Second stage.
  logic                s1_valid_r, s1_valid_nxt;
  mndt_pkg::msg_kind_t s1_kind_r;
  logic [ABITS-1:0]    s1_key_r;
  tick_t               s1_now_r;
  logic                fwd_hit_r;
  word_t               fwd_word_r;

  word_t ram_rdata;
  word_t s1_word;
  word_t s1_new_word;
  logic  s1_open;
  tick_t s1_start;
  tick_t s1_len;
  logic  s1_has_result;
  logic  s1_done;
  logic  s1_fire;
  logic  s1_we;

  // Memory write port.
  logic             ram_we;
  logic [ABITS-1:0] ram_waddr;
  word_t            ram_wdata;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  mndt_pkg::out_item_t out_data_r;

  assign in_type   = in_data.status_byte[7:4];
  assign in_key    = {in_data.status_byte[3:0], in_data.note_number};
  assign in_now    = TIME_BITS'(in_data.event_time);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_kind = mndt_pkg::MSG_OTHER;
    if (in_type == mndt_pkg::STATUS_NOTE_ON && in_data.velocity != 7'd0) begin
      in_kind = mndt_pkg::MSG_ON;
    end else if (in_type inside {mndt_pkg::STATUS_NOTE_ON, mndt_pkg::STATUS_NOTE_OFF}) begin
      in_kind = mndt_pkg::MSG_OFF;
    end
  end

  mndt_slot_ram #(
    .DATA_BITS(WBITS),
    .ADDR_BITS(ABITS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_accept),
    .raddr(in_key),
    .rdata(ram_rdata)
  );

  // The memory still holds the old word when the previous beat updated the
  // same slot in the cycle this beat was read.
  assign s1_word  = fwd_hit_r ? fwd_word_r : ram_rdata;
  assign s1_open  = s1_word[TIME_BITS];
  assign s1_start = s1_word[TIME_BITS-1:0];
  assign s1_len   = (s1_now_r >= s1_start) ? (s1_now_r - s1_start) : '0;

  assign s1_has_result = (s1_kind_r == mndt_pkg::MSG_OFF);
  assign s1_done       = !s1_has_result || !out_valid_r || !out_stall;
  assign s1_fire       = s1_valid_r && s1_done;

  always_comb begin
    s1_new_word = s1_word;
    s1_we       = 1'b0;
    case (s1_kind_r)
      mndt_pkg::MSG_ON: begin
        if (!s1_open) begin
          s1_new_word = {1'b1, s1_now_r};
          s1_we       = s1_fire;
        end
      end
      mndt_pkg::MSG_OFF: begin
        if (s1_open) begin
          s1_new_word = {1'b0, s1_start};
          s1_we       = s1_fire;
        end
      end
      default: begin
        s1_new_word = s1_word;
      end
    endcase
  end

  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_we;
      ram_waddr = s1_key_r;
      ram_wdata = s1_new_word;
    end
  end

  assign in_stall = clearing_r || (s1_valid_r && !s1_done);

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (s1_fire && s1_has_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        fwd_hit_r <= s1_fire && (s1_key_r == in_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= in_kind;
      s1_key_r   <= in_key;
      s1_now_r   <= in_now;
      fwd_word_r <= s1_new_word;
    end
    if (s1_fire && s1_has_result) begin
      out_data_r.note_channel <= s1_key_r[ABITS-1:mndt_pkg::PITCH_BITS];
      out_data_r.note_pitch   <= s1_key_r[mndt_pkg::PITCH_BITS-1:0];
      if (s1_open) begin
        out_data_r.event_kind  <= mndt_pkg::KIND_COMPLETE;
        out_data_r.start_time  <= 32'(s1_start);
        out_data_r.note_length <= 32'(s1_len);
      end else begin
        out_data_r.event_kind  <= mndt_pkg::KIND_UNMATCHED;
        out_data_r.start_time  <= '0;
        out_data_r.note_length <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "midi_note_duration_tracker_assert.svh"

  `MNDT_ASSERT_IMP(a_no_work_while_clearing, clearing_r, !s1_valid_r)
  `MNDT_ASSERT_NXT(a_stage_holds, s1_valid_r && !s1_done, s1_valid_r)
  `MNDT_ASSERT_IMP(a_fwd_only_live, fwd_hit_r, s1_valid_r || !clearing_r)
  `MNDT_ASSERT_NXT(a_result_follows_off, s1_fire && s1_has_result, out_valid_r)

endmodule

/* rtl/mndt_slot_ram.sv */
// ----------------------------------------------------------------------------
// Slot table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mndt_slot_ram #(
  parameter int DATA_BITS = 33,
  parameter int ADDR_BITS = 11
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
